[src/dncd_pkg.sv]
// shared types, calendar constants and pipeline latency for the day number to date converter
package dncd_pkg;

  typedef logic [4:0]  dom_t;
  typedef logic [3:0]  month_t;
  typedef logic [22:0] year_t;

  localparam int GREG_FIRST_DAY = 2299161;
  localparam int CENT_BIAS      = 274277;
  localparam int CENT_DIV       = 146097;
  localparam int QUAD_DIV       = 1461;
  localparam int JD_BIAS        = 1401;
  localparam int GREG_OFFS      = 38;
  localparam int YEAR_BIAS      = 4716;
  localparam int BC_LAST_YEAR   = 4713;
  localparam int MDIV           = 153;
  localparam int MDIV_MUL       = 1714;
  localparam int MDIV_SH        = 18;
  localparam int DDIV_MUL       = 205;
  localparam int DDIV_SH        = 10;
  localparam int DIV_STAGES     = 4;
  localparam int TAIL_STAGES    = 6;
  localparam int DNCD_LATENCY   = 2 * DIV_STAGES + TAIL_STAGES;

endpackage

[src/dncd_cdiv.sv]
// pipelined division by a constant: reciprocal multiply, then one correction step
module dncd_cdiv #(
  parameter int DIVIDEND_W = 34,
  parameter int DIVISOR    = 1461,
  parameter int SIDE_W     = 1
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  input  logic [DIVIDEND_W-1:0]                        in_dividend,
  input  logic [SIDE_W-1:0]                            in_side,
  output logic                                         out_valid,
  output logic [DIVIDEND_W-$clog2(DIVISOR+1):0]        out_quotient,
  output logic [$clog2(DIVISOR+1)-1:0]                 out_remainder,
  output logic [SIDE_W-1:0]                            out_side
);

  localparam int DV_W = $clog2(DIVISOR + 1);
  localparam int Q_W  = DIVIDEND_W - DV_W + 1;
  localparam int M_W  = Q_W + 1;
  localparam int LO_W = DIVIDEND_W / 2;
  localparam int HI_W = DIVIDEND_W - LO_W;
  localparam int PL_W = LO_W + M_W;
  localparam int PH_W = HI_W + M_W;
  localparam int P_W  = DIVIDEND_W + M_W;
  localparam longint unsigned       RECIP   = (64'd1 << DIVIDEND_W) / 64'(DIVISOR);
  localparam logic [M_W-1:0]        RECIP_C = M_W'(RECIP);
  localparam logic [DV_W:0]         DIV_C   = (DV_W + 1)'(DIVISOR);
  localparam logic [DIVIDEND_W-1:0] DIV_X   = DIVIDEND_W'(DIVISOR);

  // partial products of the dividend and the reciprocal
  logic                  s1_vld_r;
  logic [DIVIDEND_W-1:0] s1_x_r;
  logic [PL_W-1:0]       s1_pl_r;
  logic [PH_W-1:0]       s1_ph_r;
  logic [SIDE_W-1:0]     s1_side_r;
  logic [PL_W-1:0]       pl_nxt;
  logic [PH_W-1:0]       ph_nxt;

  always_comb begin
    pl_nxt = PL_W'(in_dividend[LO_W-1:0]) * PL_W'(RECIP_C);
    ph_nxt = PH_W'(in_dividend[DIVIDEND_W-1:LO_W]) * PH_W'(RECIP_C);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_valid;
    end
    s1_x_r    <= in_dividend;
    s1_pl_r   <= pl_nxt;
    s1_ph_r   <= ph_nxt;
    s1_side_r <= in_side;
  end

  // quotient estimate, low by at most one
  logic                  s2_vld_r;
  logic [DIVIDEND_W-1:0] s2_x_r;
  logic [Q_W-1:0]        s2_q_r;
  logic [SIDE_W-1:0]     s2_side_r;
  logic [P_W-1:0]        prod_nxt;

  assign prod_nxt = P_W'(s1_pl_r) + (P_W'(s1_ph_r) << LO_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_x_r    <= s1_x_r;
    s2_q_r    <= prod_nxt[DIVIDEND_W +: Q_W];
    s2_side_r <= s1_side_r;
  end

  // remainder of the estimate, below twice the divisor
  logic                  s3_vld_r;
  logic [DV_W:0]         s3_rem_r;
  logic [Q_W-1:0]        s3_q_r;
  logic [SIDE_W-1:0]     s3_side_r;
  logic [DIVIDEND_W-1:0] back_nxt;

  assign back_nxt = s2_x_r - DIVIDEND_W'(s2_q_r) * DIV_X;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_rem_r  <= back_nxt[DV_W:0];
    s3_q_r    <= s2_q_r;
    s3_side_r <= s2_side_r;
  end

  // correction step
  logic              s4_vld_r;
  logic [DV_W-1:0]   s4_rem_r;
  logic [Q_W-1:0]    s4_q_r;
  logic [SIDE_W-1:0] s4_side_r;
  logic              ge;
  logic [DV_W-1:0]   rem_nxt;
  logic [Q_W-1:0]    quo_nxt;

  always_comb begin
    ge      = (s3_rem_r >= DIV_C);
    rem_nxt = ge ? DV_W'(s3_rem_r - DIV_C) : s3_rem_r[DV_W-1:0];
    quo_nxt = s3_q_r + Q_W'(ge);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_rem_r  <= rem_nxt;
    s4_q_r    <= quo_nxt;
    s4_side_r <= s3_side_r;
  end

  assign out_valid     = s4_vld_r;
  assign out_quotient  = s4_q_r;
  assign out_remainder = s4_rem_r;
  assign out_side      = s4_side_r;

endmodule

[src/day_number_to_calendar_date_top.sv]
// top level: day number to calendar date conversion pipeline
//
// One transaction per clock cycle: a day number is taken whenever start is high and busy is
// low, and its date appears on the out_ ports for one cycle with out_valid high, in the order
// taken, for any DAY_BITS. The pipeline holds two divisions by constants (146097 and
// 1461), each a reciprocal multiply with one correction step over four register stages, plus
// an input stage, a gregorian correction stage and four short stages for the month, day and
// year. busy is high during reset and drops at the first clock edge after reset is released.
// There is no backpressure: each result must be captured in the cycle that out_valid marks it.
module day_number_to_calendar_date_top #(
  parameter int DAY_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [DAY_BITS-1:0]   in_day_number,
  output logic                  out_valid,
  output dncd_pkg::dom_t        out_day_of_month,
  output dncd_pkg::month_t      out_month,
  output dncd_pkg::year_t       out_year_magnitude,
  output logic                  out_is_bc
);
  import dncd_pkg::*;

  localparam int A_W  = DAY_BITS + 3;
  localparam int QA_W = A_W - $clog2(CENT_DIV + 1) + 1;
  localparam int QB_W = A_W - $clog2(QUAD_DIV + 1) + 1;
  localparam int RB_W = $clog2(QUAD_DIV + 1);
  localparam int S_W  = QB_W + 1;
  localparam int Y_W  = (S_W > 24) ? S_W : 24;

  // input stage
  logic                busy_r;
  logic                s0_vld_r;
  logic [DAY_BITS-1:0] s0_jd_r;
  logic [A_W-1:0]      s0_dva_r;
  logic                accept;

  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      s0_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      s0_vld_r <= accept;
    end
    s0_jd_r  <= in_day_number;
    s0_dva_r <= A_W'({in_day_number, 2'b00}) + A_W'(CENT_BIAS);
  end

  // centuries since the gregorian epoch
  logic                a_vld;
  logic [QA_W-1:0]     a_cent;
  logic [DAY_BITS-1:0] a_jd;

  dncd_cdiv #(
    .DIVIDEND_W (A_W),
    .DIVISOR    (CENT_DIV),
    .SIDE_W     (DAY_BITS)
  ) u_cent_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (s0_vld_r),
    .in_dividend   (s0_dva_r),
    .in_side       (s0_jd_r),
    .out_valid     (a_vld),
    .out_quotient  (a_cent),
    .out_remainder (),
    .out_side      (a_jd)
  );

  // gregorian correction and quad-year numerator
  logic                q_vld_r;
  logic [A_W-1:0]      q_quad_r;
  logic [QA_W+1:0]     cent3;
  logic [QA_W-1:0]     greg_adj;
  logic                is_greg;
  logic [DAY_BITS:0]   shifted;

  always_comb begin
    is_greg  = (a_jd >= DAY_BITS'(GREG_FIRST_DAY));
    cent3    = (QA_W + 2)'(a_cent) * (QA_W + 2)'(3);
    greg_adj = QA_W'((cent3 >> 2) - (QA_W + 2)'(GREG_OFFS));
    shifted  = (DAY_BITS + 1)'(a_jd) + (DAY_BITS + 1)'(JD_BIAS)
             + (is_greg ? (DAY_BITS + 1)'(greg_adj) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= a_vld;
    end
    q_quad_r <= {shifted, 2'b11};
  end

  // years since the epoch and day within the march-based year
  logic            b_vld;
  logic [QB_W-1:0] b_q1;
  logic [RB_W-1:0] b_rem;

  dncd_cdiv #(
    .DIVIDEND_W (A_W),
    .DIVISOR    (QUAD_DIV),
    .SIDE_W     (1)
  ) u_quad_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (q_vld_r),
    .in_dividend   (q_quad_r),
    .in_side       (1'b0),
    .out_valid     (b_vld),
    .out_quotient  (b_q1),
    .out_remainder (b_rem),
    .out_side      ()
  );

  // month numerator
  logic            h_vld_r;
  logic [10:0]     h_h_r;
  logic [QB_W-1:0] h_q1_r;
  logic [8:0]      doy;

  assign doy = b_rem[RB_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else begin
      h_vld_r <= b_vld;
    end
    h_h_r  <= 11'({doy, 2'b00}) + 11'(doy) + 11'd2;
    h_q1_r <= b_q1;
  end

  // month index by reciprocal multiply
  logic            m_vld_r;
  logic [3:0]      m_q_r;
  logic [10:0]     m_h_r;
  logic [QB_W-1:0] m_q1_r;
  logic [21:0]     mprod;

  assign mprod = 22'(h_h_r) * 22'(MDIV_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= h_vld_r;
    end
    m_q_r  <= mprod[MDIV_SH +: 4];
    m_h_r  <= h_h_r;
    m_q1_r <= h_q1_r;
  end

  // month, day remainder and year count
  logic           t_vld_r;
  logic [7:0]     t_rem_r;
  month_t         t_month_r;
  logic [S_W-1:0] t_s_r;
  month_t         month_nxt;
  logic [10:0]    rem153;

  always_comb begin
    rem153    = m_h_r - 11'(m_q_r) * 11'(MDIV);
    month_nxt = (m_q_r < 4'd10) ? m_q_r + 4'd3 : m_q_r - 4'd9;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else begin
      t_vld_r <= m_vld_r;
    end
    t_rem_r   <= rem153[7:0];
    t_month_r <= month_nxt;
    t_s_r     <= S_W'(m_q1_r) + S_W'(month_nxt <= 4'd2);
  end

  // output register
  logic           o_vld_r;
  dom_t           o_dom_r;
  month_t         o_month_r;
  year_t          o_year_r;
  logic           o_bc_r;
  logic [15:0]    dprod;
  logic [Y_W-1:0] s_x;
  logic [Y_W-1:0] year_full;
  logic           bc_nxt;

  always_comb begin
    dprod     = 16'(t_rem_r) * 16'(DDIV_MUL);
    s_x       = Y_W'(t_s_r);
    bc_nxt    = (s_x <= Y_W'(YEAR_BIAS));
    year_full = bc_nxt ? Y_W'(YEAR_BIAS + 1) - s_x : s_x - Y_W'(YEAR_BIAS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= t_vld_r;
    end
    o_dom_r   <= dprod[DDIV_SH +: 5] + 5'd1;
    o_month_r <= t_month_r;
    o_year_r  <= year_full[22:0];
    o_bc_r    <= bc_nxt;
  end

  assign out_valid          = o_vld_r;
  assign out_day_of_month   = o_dom_r;
  assign out_month          = o_month_r;
  assign out_year_magnitude = o_year_r;
  assign out_is_bc          = o_bc_r;

endmodule

[src/dncd_chk.sv]
// port-level checker for the day number to date converter, bound to the top level
module dncd_chk #(
  parameter int DAY_BITS = 31
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input dncd_pkg::dom_t        out_day_of_month,
  input dncd_pkg::month_t      out_month,
  input dncd_pkg::year_t       out_year_magnitude,
  input logic                  out_is_bc
);
  import dncd_pkg::*;

  localparam int LAT = DNCD_LATENCY;

  logic [LAT-1:0] hist_r;
  logic [LAT-1:0] hist_nxt;
  logic           short_month;

  assign hist_nxt    = {hist_r[LAT-2:0], start & ~busy};
  assign short_month = (out_month == 4'd4) || (out_month == 4'd6) ||
                       (out_month == 4'd9) || (out_month == 4'd11);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  // one result per transaction at fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == hist_r[LAT-1])
    else $error("result strobe does not match accepted transaction");

  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("busy rose outside reset");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_day_of_month >= 5'd1 && out_day_of_month <= 5'd31 &&
                  out_month >= 4'd1 && out_month <= 4'd12)
    else $error("day or month out of range");

  a_month_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!short_month || out_day_of_month <= 5'd30) &&
                  (out_month != 4'd2 || out_day_of_month <= 5'd29))
    else $error("day beyond end of month");

  a_bc_year: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_bc |-> out_year_magnitude >= 23'd1 &&
                               out_year_magnitude <= 23'(BC_LAST_YEAR))
    else $error("bc year out of range");

endmodule

bind day_number_to_calendar_date_top dncd_chk #(
  .DAY_BITS (DAY_BITS)
) u_dncd_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_day_of_month   (out_day_of_month),
  .out_month          (out_month),
  .out_year_magnitude (out_year_magnitude),
  .out_is_bc          (out_is_bc)
);
